### src/hfci_pkg.sv
`default_nettype none

package hfci_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_BOUND,
        ST_PROBE,
        ST_MID,
        ST_ROW,
        ST_CELL,
        ST_LOW,
        ST_HIGH,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_G4,
        ST_N1,
        ST_N2,
        ST_N3,
        ST_N4,
        ST_N5,
        ST_DIV0,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    localparam logic [2:0] OP_QUERY   = 3'd0;
    localparam logic [2:0] OP_X_COORD = 3'd1;
    localparam logic [2:0] OP_Z_COORD = 3'd2;
    localparam logic [2:0] OP_TOP     = 3'd3;
    localparam logic [2:0] OP_BOTTOM  = 3'd4;
    localparam logic [2:0] OP_SOLID   = 3'd5;

    localparam logic [1:0] CLASS_OUT   = 2'd0;
    localparam logic [1:0] CLASS_VOID  = 2'd1;
    localparam logic [1:0] CLASS_SOLID = 2'd2;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_DUAL    = 2'd2;

    localparam int ACC_W     = 100;
    localparam int REM_W     = 68;
    localparam int DIV_STEPS = 36;
    localparam int CNT_W     = 6;

endpackage

`default_nettype wire

### src/heightfield_column_interpolate.sv
// Column interpolation over a triangulated heightfield lattice. Load requests (x and z vertex
// coordinates, top and bottom heights, solid flags) write the lattice memories. A query
// request places its point by two binary searches, picks the triangle with a shared 32x32
// multiplier, and divides with a restoring divider that yields one quotient bit per cycle
// for a 36-bit quotient. With the dual register set, a query also interpolates the bottom
// surface; s_ready is low while a query is in progress. The result waits in an output
// register while the next request is taken.
`default_nettype none

module heightfield_column_interpolate
    import hfci_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic [15:0]        s_entry_index,
    input  wire logic signed [31:0] s_entry_value,
    input  wire logic signed [31:0] s_query_x,
    input  wire logic signed [31:0] s_query_z,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_column_class,
    output logic signed [31:0]      m_top_height,
    output logic signed [31:0]      m_bottom_height,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int XW         = $clog2(MAX_COLUMNS);
    localparam int ZW         = $clog2(MAX_ROWS);
    localparam int SW         = (XW > ZW) ? XW : ZW;
    localparam int MAXN       = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int NW         = $clog2(MAXN + 1);
    localparam int GRID_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int GW         = $clog2(GRID_DEPTH);

    state_t state_reg, state_next;

    logic [8:0] cols_reg, rows_reg;
    logic       dual_reg;

    logic signed [31:0] x_mem   [MAX_COLUMNS];
    logic signed [31:0] z_mem   [MAX_ROWS];
    logic signed [31:0] top_mem [GRID_DEPTH];
    logic signed [31:0] bot_mem [GRID_DEPTH];
    logic               sol_mem [GRID_DEPTH];

    logic signed [31:0] x_rd_reg, z_rd_reg, top_rd_reg, bot_rd_reg;
    logic               sol_rd_reg;

    logic [XW-1:0] x_raddr;
    logic [ZW-1:0] z_raddr;
    logic [GW-1:0] g_raddr, s_raddr;

    logic signed [31:0] qx_reg, qz_reg;
    logic [NW-1:0]      w_reg, h_reg;
    logic               axis_reg, surf_reg;
    logic [SW-1:0]      lo_reg, hi_reg;
    logic [XW-1:0]      ci_reg;
    logic [ZW-1:0]      cj_reg;
    logic [GW-1:0]      row_reg;
    logic signed [31:0] x0_reg, z0_reg;
    logic [31:0]        un_reg, ud_reg, vn_reg, vd_reg;
    logic signed [31:0] t00_reg, t10_reg, t01_reg, t11_reg;
    logic signed [31:0] b00_reg, b10_reg, b01_reg, b11_reg;
    logic [63:0]        prod_reg, p1_reg, p2_reg, den_reg;
    logic               tri_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIV_STEPS-1:0] qd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    logic [1:0]         res_class_reg;
    logic signed [31:0] res_top_reg, res_bot_reg;
    logic               m_valid_reg;
    logic [1:0]         m_class_reg;
    logic signed [31:0] m_top_reg, m_bot_reg;

    logic        accept, cfg_wr;
    logic        x_we, z_we, top_we, bot_we, sol_we;
    logic [NW-1:0] w_sat, h_sat, n_cur;
    logic [SW-1:0] nm1, mid, span;
    logic        span_gt1;
    logic signed [31:0] crd, qv;
    logic [GW-1:0] i00;
    logic [32:0] sun, sud, svn, svd;
    logic        degen;
    logic [31:0] mul_a, mul_b;
    logic signed [31:0] h00, h10, h01, h11;
    logic [32:0] d_a, d_b;
    logic [31:0] mag_a, mag_b;
    logic        add_hi, add_neg;
    logic [ACC_W-1:0] term_base, term, num, num_mag;
    logic [REM_W-1:0] den2, trial;
    logic        take;
    logic [31:0] res32;
    logic signed [31:0] hgt;
    logic        out_load;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= '0;
            rows_reg <= '0;
            dual_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_COLUMNS: cols_reg <= pwdata[8:0];
                REG_ROWS:    rows_reg <= pwdata[8:0];
                REG_DUAL:    dual_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COLUMNS: prdata = {23'd0, cols_reg};
            REG_ROWS:    prdata = {23'd0, rows_reg};
            REG_DUAL:    prdata = {31'd0, dual_reg};
            default:     prdata = '0;
        endcase
    end

    assign x_we   = accept && s_operation == OP_X_COORD
                    && ({16'd0, s_entry_index} < 32'(MAX_COLUMNS));
    assign z_we   = accept && s_operation == OP_Z_COORD
                    && ({16'd0, s_entry_index} < 32'(MAX_ROWS));
    assign top_we = accept && s_operation == OP_TOP
                    && ({16'd0, s_entry_index} < 32'(GRID_DEPTH));
    assign bot_we = accept && s_operation == OP_BOTTOM
                    && ({16'd0, s_entry_index} < 32'(GRID_DEPTH));
    assign sol_we = accept && s_operation == OP_SOLID
                    && ({16'd0, s_entry_index} < 32'(GRID_DEPTH));

    always_ff @(posedge aclk) begin
        if (x_we) begin
            x_mem[XW'(s_entry_index)] <= s_entry_value;
        end
        x_rd_reg <= x_mem[x_raddr];
    end

    always_ff @(posedge aclk) begin
        if (z_we) begin
            z_mem[ZW'(s_entry_index)] <= s_entry_value;
        end
        z_rd_reg <= z_mem[z_raddr];
    end

    always_ff @(posedge aclk) begin
        if (top_we) begin
            top_mem[GW'(s_entry_index)] <= s_entry_value;
        end
        top_rd_reg <= top_mem[g_raddr];
    end

    always_ff @(posedge aclk) begin
        if (bot_we) begin
            bot_mem[GW'(s_entry_index)] <= s_entry_value;
        end
        bot_rd_reg <= bot_mem[g_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sol_we) begin
            sol_mem[GW'(s_entry_index)] <= s_entry_value[0];
        end
        sol_rd_reg <= sol_mem[s_raddr];
    end

    assign w_sat = ({23'd0, cols_reg} > 32'(MAX_COLUMNS)) ? NW'(MAX_COLUMNS) : NW'(cols_reg);
    assign h_sat = ({23'd0, rows_reg} > 32'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(rows_reg);

    assign n_cur    = axis_reg ? h_reg : w_reg;
    assign nm1      = SW'(n_cur - NW'(1));
    assign span     = hi_reg - lo_reg;
    assign mid      = lo_reg + (span >> 1);
    assign span_gt1 = span > SW'(1);
    assign crd      = axis_reg ? z_rd_reg : x_rd_reg;
    assign qv       = axis_reg ? qz_reg : qx_reg;

    assign i00     = row_reg + GW'(ci_reg);
    assign s_raddr = row_reg - GW'(cj_reg) + GW'(ci_reg);

    assign sun   = {qx_reg[31], qx_reg} - {x0_reg[31], x0_reg};
    assign sud   = {x_rd_reg[31], x_rd_reg} - {x0_reg[31], x0_reg};
    assign svn   = {qz_reg[31], qz_reg} - {z0_reg[31], z0_reg};
    assign svd   = {z_rd_reg[31], z_rd_reg} - {z0_reg[31], z0_reg};
    assign degen = sud[32] || sud == '0 || svd[32] || svd == '0;

    assign h00 = surf_reg ? b00_reg : t00_reg;
    assign h10 = surf_reg ? b10_reg : t10_reg;
    assign h01 = surf_reg ? b01_reg : t01_reg;
    assign h11 = surf_reg ? b11_reg : t11_reg;

    assign d_a   = tri_reg ? ({h10[31], h10} - {h00[31], h00})
                           : ({h11[31], h11} - {h01[31], h01});
    assign d_b   = tri_reg ? ({h11[31], h11} - {h10[31], h10})
                           : ({h01[31], h01} - {h00[31], h00});
    assign mag_a = d_a[32] ? 32'(-d_a) : d_a[31:0];
    assign mag_b = d_b[32] ? 32'(-d_b) : d_b[31:0];

    assign add_hi    = (state_reg == ST_N3) || (state_reg == ST_N5);
    assign add_neg   = (state_reg == ST_N2 || state_reg == ST_N3) ? d_a[32] : d_b[32];
    assign term_base = ACC_W'(prod_reg);
    assign term      = add_hi ? (term_base << 32) : term_base;

    assign num     = (acc_reg << 1) + ACC_W'(den_reg);
    assign num_mag = num[ACC_W-1] ? -num : num;
    assign den2    = REM_W'({den_reg, 1'b0});
    assign trial   = {rem_reg[REM_W-2:0], qd_reg[DIV_STEPS-1]};
    assign take    = trial >= den2;
    assign res32   = neg_reg ? ((rem_reg != '0) ? ~qd_reg[31:0] : -qd_reg[31:0])
                             : qd_reg[31:0];
    assign hgt     = h00 + $signed(res32);

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        x_raddr    = XW'(lo_reg);
        z_raddr    = ZW'(lo_reg);
        g_raddr    = i00;
        mul_a      = un_reg;
        mul_b      = vd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OP_QUERY) begin
                    if (w_sat < NW'(2) || h_sat < NW'(2)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                x_raddr    = '0;
                z_raddr    = '0;
                state_next = ST_LAST;
            end
            ST_LAST: begin
                x_raddr    = XW'(nm1);
                z_raddr    = ZW'(nm1);
                state_next = (qv < crd) ? ST_DONE : ST_BOUND;
            end
            ST_BOUND: begin
                state_next = (qv > crd) ? ST_DONE : ST_PROBE;
            end
            ST_PROBE: begin
                x_raddr = XW'(mid);
                z_raddr = ZW'(mid);
                if (span_gt1) begin
                    state_next = ST_MID;
                end else if (axis_reg) begin
                    state_next = ST_ROW;
                end else begin
                    state_next = ST_FIRST;
                end
            end
            ST_MID:  state_next = ST_PROBE;
            ST_ROW:  state_next = ST_CELL;
            ST_CELL: begin
                x_raddr    = ci_reg;
                z_raddr    = cj_reg;
                state_next = ST_LOW;
            end
            ST_LOW: begin
                x_raddr    = ci_reg + XW'(1);
                z_raddr    = cj_reg + ZW'(1);
                state_next = sol_rd_reg ? ST_HIGH : ST_DONE;
            end
            ST_HIGH: begin
                state_next = degen ? ST_DONE : ST_G1;
            end
            ST_G1: begin
                g_raddr    = i00 + GW'(1);
                state_next = ST_G2;
            end
            ST_G2: begin
                g_raddr    = i00 + GW'(w_reg);
                mul_a      = vn_reg;
                mul_b      = ud_reg;
                state_next = ST_G3;
            end
            ST_G3: begin
                g_raddr    = i00 + GW'(w_reg) + GW'(1);
                mul_a      = ud_reg;
                mul_b      = vd_reg;
                state_next = ST_G4;
            end
            ST_G4: state_next = ST_N1;
            ST_N1: begin
                mul_a      = mag_a;
                mul_b      = p1_reg[31:0];
                state_next = ST_N2;
            end
            ST_N2: begin
                mul_a      = mag_a;
                mul_b      = p1_reg[63:32];
                state_next = ST_N3;
            end
            ST_N3: begin
                mul_a      = mag_b;
                mul_b      = p2_reg[31:0];
                state_next = ST_N4;
            end
            ST_N4: begin
                mul_a      = mag_b;
                mul_b      = p2_reg[63:32];
                state_next = ST_N5;
            end
            ST_N5:   state_next = ST_DIV0;
            ST_DIV0: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = (!surf_reg && dual_reg) ? ST_N1 : ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OP_QUERY) begin
                    qx_reg        <= s_query_x;
                    qz_reg        <= s_query_z;
                    w_reg         <= w_sat;
                    h_reg         <= h_sat;
                    axis_reg      <= 1'b0;
                    surf_reg      <= 1'b0;
                    res_class_reg <= CLASS_OUT;
                    res_top_reg   <= '0;
                    res_bot_reg   <= '0;
                end
            end
            ST_BOUND: begin
                lo_reg <= '0;
                hi_reg <= nm1;
            end
            ST_MID: begin
                if (crd <= qv) begin
                    lo_reg <= mid;
                end else begin
                    hi_reg <= mid;
                end
            end
            ST_PROBE: begin
                if (!span_gt1) begin
                    if (axis_reg) begin
                        cj_reg <= ZW'(lo_reg);
                    end else begin
                        ci_reg   <= XW'(lo_reg);
                        axis_reg <= 1'b1;
                    end
                end
            end
            ST_ROW: row_reg <= GW'(cj_reg) * GW'(w_reg);
            ST_LOW: begin
                x0_reg <= x_rd_reg;
                z0_reg <= z_rd_reg;
                if (!sol_rd_reg) begin
                    res_class_reg <= CLASS_VOID;
                end
            end
            ST_HIGH: begin
                un_reg <= sun[31:0];
                ud_reg <= sud[31:0];
                vn_reg <= svn[31:0];
                vd_reg <= svd[31:0];
                if (!degen) begin
                    res_class_reg <= CLASS_SOLID;
                end
            end
            ST_G1: begin
                t00_reg <= top_rd_reg;
                b00_reg <= bot_rd_reg;
            end
            ST_G2: begin
                t10_reg <= top_rd_reg;
                b10_reg <= bot_rd_reg;
                p1_reg  <= prod_reg;
            end
            ST_G3: begin
                t01_reg <= top_rd_reg;
                b01_reg <= bot_rd_reg;
                p2_reg  <= prod_reg;
            end
            ST_G4: begin
                t11_reg <= top_rd_reg;
                b11_reg <= bot_rd_reg;
                den_reg <= prod_reg;
                tri_reg <= p1_reg >= p2_reg;
            end
            ST_N1: acc_reg <= '0;
            ST_N2, ST_N3, ST_N4, ST_N5: begin
                acc_reg <= add_neg ? (acc_reg - term) : (acc_reg + term);
            end
            ST_DIV0: begin
                rem_reg <= REM_W'(num_mag >> DIV_STEPS);
                qd_reg  <= num_mag[DIV_STEPS-1:0];
                neg_reg <= num[ACC_W-1];
                cnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg <= take ? (trial - den2) : trial;
                qd_reg  <= {qd_reg[DIV_STEPS-2:0], take};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_FIN: begin
                if (surf_reg) begin
                    res_bot_reg <= hgt;
                end else begin
                    res_top_reg <= hgt;
                    res_bot_reg <= hgt;
                    surf_reg    <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_class_reg <= res_class_reg;
            m_top_reg   <= res_top_reg;
            m_bot_reg   <= res_bot_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_column_class  = m_class_reg;
    assign m_top_height    = m_top_reg;
    assign m_bottom_height = m_bot_reg;

`ifndef SYNTHESIS
    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MID) |-> (lo_reg < hi_reg))
        else $error("search bounds crossed");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider ran past its step count");

    a_fin_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |=> (state_reg == ST_N1 || state_reg == ST_DONE))
        else $error("bad exit from finish step");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == OP_QUERY) |=> !s_ready)
        else $error("query request did not hold off input");
`endif

endmodule

`default_nettype wire

### tb/heightfield_column_checker.sv
`timescale 1ns / 100ps

module heightfield_column_checker
    import hfci_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic [15:0]        s_entry_index,
    input  wire logic signed [31:0] s_entry_value,
    input  wire logic signed [31:0] s_query_x,
    input  wire logic signed [31:0] s_query_z,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [1:0]         m_column_class,
    input  wire logic signed [31:0] m_top_height,
    input  wire logic signed [31:0] m_bottom_height,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    output int                      errors,
    output int                      pending,
    output int                      outs_seen,
    output int                      voids_seen,
    output int                      solids_seen
);

    typedef struct packed {
        logic [1:0]         cls;
        logic signed [31:0] top;
        logic signed [31:0] bot;
    } column_t;

    logic signed [31:0] x_tab [256];
    logic signed [31:0] z_tab [256];
    logic signed [31:0] top_tab [65536];
    logic signed [31:0] bot_tab [65536];
    logic               solid_tab [65536];
    logic [8:0]         cols;
    logic [8:0]         rows;
    logic               dual;
    column_t            expected_cols [$];

    initial begin
        errors      = 0;
        pending     = 0;
        outs_seen   = 0;
        voids_seen  = 0;
        solids_seen = 0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic signed [31:0] coord(bit on_z, int i);
        return on_z ? z_tab[i] : x_tab[i];
    endfunction

    function automatic bit locate(bit on_z, int n, logic signed [31:0] p, output int slot);
        int lo;
        int hi;
        int mid;
        lo   = 0;
        hi   = n - 1;
        slot = 0;
        if (p < coord(on_z, 0) || p > coord(on_z, n - 1)) return 0;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (coord(on_z, mid) <= p) lo = mid;
            else hi = mid;
        end
        slot = (lo > n - 2) ? n - 2 : lo;
        return 1;
    endfunction

    function automatic logic signed [31:0] blend(logic signed [31:0] h00, logic signed [31:0] h10,
                                                 logic signed [31:0] h01, logic signed [31:0] h11,
                                                 bit tri_a, logic [63:0] un, logic [63:0] ud,
                                                 logic [63:0] vn, logic [63:0] vd);
        logic signed [127:0] d_u;
        logic signed [127:0] d_v;
        logic signed [127:0] w_u;
        logic signed [127:0] w_v;
        logic signed [127:0] n;
        logic signed [127:0] dd;
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] q;
        w_u = {64'd0, un * vd};
        w_v = {64'd0, vn * ud};
        if (tri_a) begin
            d_u = h10 - h00;
            d_v = h11 - h10;
        end else begin
            d_u = h11 - h01;
            d_v = h01 - h00;
        end
        n   = d_u * w_u + d_v * w_v;
        dd  = {64'd0, ud * vd};
        num = (n <<< 1) + dd;
        den = dd <<< 1;
        q   = num / den;
        if (num < 0 && (num % den) != 0) q = q - 1;
        return h00 + q[31:0];
    endfunction

    function automatic column_t predict_column(logic signed [31:0] qx, logic signed [31:0] qz);
        column_t    r;
        int         w;
        int         h;
        int         ci;
        int         cj;
        int         i00;
        longint     sun;
        longint     sud;
        longint     svn;
        longint     svd;
        logic [127:0] lhs;
        logic [127:0] rhs;
        bit         tri_a;
        r = '0;
        w = (cols > 256) ? 256 : int'(cols);
        h = (rows > 256) ? 256 : int'(rows);
        if (w < 2 || h < 2) return r;
        if (!locate(0, w, qx, ci)) return r;
        if (!locate(1, h, qz, cj)) return r;
        if (!solid_tab[cj * (w - 1) + ci]) begin
            r.cls = CLASS_VOID;
            return r;
        end
        sun = longint'(qx) - longint'(x_tab[ci]);
        sud = longint'(x_tab[ci + 1]) - longint'(x_tab[ci]);
        svn = longint'(qz) - longint'(z_tab[cj]);
        svd = longint'(z_tab[cj + 1]) - longint'(z_tab[cj]);
        if (sud <= 0 || svd <= 0) return r;
        i00   = cj * w + ci;
        lhs   = {64'd0, sun} * {64'd0, svd};
        rhs   = {64'd0, svn} * {64'd0, sud};
        tri_a = lhs >= rhs;
        r.cls = CLASS_SOLID;
        r.top = blend(top_tab[i00], top_tab[i00 + 1], top_tab[i00 + w], top_tab[i00 + w + 1],
                      tri_a, sun, sud, svn, svd);
        r.bot = dual ? blend(bot_tab[i00], bot_tab[i00 + 1], bot_tab[i00 + w],
                             bot_tab[i00 + w + 1], tri_a, sun, sud, svn, svd) : r.top;
        return r;
    endfunction

    always @(posedge aclk) begin
        column_t e;
        if (!aresetn) begin
            cols = '0;
            rows = '0;
            dual = 1'b0;
            expected_cols.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_COLUMNS: cols = pwdata[8:0];
                    REG_ROWS:    rows = pwdata[8:0];
                    REG_DUAL:    dual = pwdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_operation)
                    OP_QUERY:   expected_cols = {expected_cols,
                                                 predict_column(s_query_x, s_query_z)};
                    OP_X_COORD: if (s_entry_index < 256) x_tab[s_entry_index] = s_entry_value;
                    OP_Z_COORD: if (s_entry_index < 256) z_tab[s_entry_index] = s_entry_value;
                    OP_TOP:     top_tab[s_entry_index] = s_entry_value;
                    OP_BOTTOM:  bot_tab[s_entry_index] = s_entry_value;
                    OP_SOLID:   solid_tab[s_entry_index] = s_entry_value[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_cols.size() == 0) begin
                    report_mismatch("unexpected result", {30'd0, m_column_class}, 32'd0);
                end else begin
                    e = expected_cols.pop_front();
                    case (e.cls)
                        CLASS_OUT:  outs_seen++;
                        CLASS_VOID: voids_seen++;
                        default:    solids_seen++;
                    endcase
                    if (m_column_class !== e.cls)
                        report_mismatch("column_class", {30'd0, m_column_class}, {30'd0, e.cls});
                    if (m_top_height !== e.top)
                        report_mismatch("top_height", m_top_height, e.top);
                    if (m_bottom_height !== e.bot)
                        report_mismatch("bottom_height", m_bottom_height, e.bot);
                end
            end
            pending <= expected_cols.size();
        end
    end

endmodule

### tb/heightfield_column_interpolate_tb.sv
`timescale 1ns / 100ps

module heightfield_column_interpolate_tb;
    import hfci_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 200;
    localparam int ITEM_TARGET = 750;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_operation;
    logic [15:0]        s_entry_index;
    logic signed [31:0] s_entry_value;
    logic signed [31:0] s_query_x;
    logic signed [31:0] s_query_z;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_column_class;
    logic signed [31:0] m_top_height;
    logic signed [31:0] m_bottom_height;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int     errors;
    int     pending;
    int     outs_seen;
    int     voids_seen;
    int     solids_seen;
    int     cycles;
    int     requests;
    int     cfg_writes;
    int     send_idle;
    int     recv_idle;
    longint ax [2][256];

    heightfield_column_interpolate dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_entry_index(s_entry_index), .s_entry_value(s_entry_value),
        .s_query_x(s_query_x), .s_query_z(s_query_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_column_class(m_column_class),
        .m_top_height(m_top_height), .m_bottom_height(m_bottom_height),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    heightfield_column_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_entry_index(s_entry_index), .s_entry_value(s_entry_value),
        .s_query_x(s_query_x), .s_query_z(s_query_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_column_class(m_column_class),
        .m_top_height(m_top_height), .m_bottom_height(m_bottom_height),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .errors(errors), .pending(pending), .outs_seen(outs_seen),
        .voids_seen(voids_seen), .solids_seen(solids_seen)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic set_idling();
        if (requests < 250) begin
            send_idle = 22;
            recv_idle = 78;
        end else if (requests < 500) begin
            send_idle = 78;
            recv_idle = 22;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send_req(logic [2:0] op, logic [15:0] idx, logic [31:0] val,
                            logic [31:0] qx, logic [31:0] qz);
        set_idling();
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_entry_index <= idx;
        s_entry_value <= val;
        s_query_x     <= qx;
        s_query_z     <= qz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests++;
    endtask

    task automatic load(logic [2:0] op, logic [15:0] idx, logic [31:0] val);
        send_req(op, idx, val, $urandom, $urandom);
    endtask

    task automatic query(logic [31:0] qx, logic [31:0] qz);
        send_req(OP_QUERY, 16'($urandom), $urandom, qx, qz);
    endtask

    // hold the sender until every result is back and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    task automatic configure(int c, int r, int d);
        drain();
        write_reg(REG_COLUMNS, c);
        write_reg(REG_ROWS, r);
        write_reg(REG_DUAL, d);
    endtask

    function automatic logic [31:0] rand_height();
        if ($urandom_range(1)) return $urandom;
        return $urandom_range(0, 1 << 20) - (1 << 19);
    endfunction

    task automatic fill_axis(int a, int n, int style);
        int     i;
        int     flat;
        longint v;
        flat = (style == 2) ? $urandom_range(0, n - 2) : -1;
        for (i = 0; i < n; i++) begin
            if (style == 1) v = -64'sd2147483648 + (i * 64'sd4294967295) / (n - 1);
            else if (i == 0) v = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            else v = ax[a][i - 1] + ((i - 1 == flat) ? 0 : $urandom_range(1, 1 << 20));
            ax[a][i] = v;
            load((a == 0) ? OP_X_COORD : OP_Z_COORD, 16'(i), v[31:0]);
        end
    endtask

    task automatic build_lattice(int w, int h, int style, int solid_pct);
        int          k;
        logic [31:0] v;
        fill_axis(0, w, style);
        fill_axis(1, h, style);
        for (k = 0; k < w * h; k++) begin
            load(OP_TOP, 16'(k), rand_height());
            load(OP_BOTTOM, 16'(k), rand_height());
        end
        for (k = 0; k < (w - 1) * (h - 1); k++) begin
            v    = $urandom;
            v[0] = ($urandom_range(99) < solid_pct);
            load(OP_SOLID, 16'(k), v);
        end
    endtask

    function automatic longint point_in(int a, int c);
        longint lo;
        longint d;
        lo = ax[a][c];
        d  = ax[a][c + 1] - lo;
        if (d <= 0) return lo;
        case ($urandom_range(5))
            0: return lo;
            1: return lo + d;
            default: return lo + longint'({$urandom, $urandom} % (d + 1));
        endcase
    endfunction

    task automatic gen_query(int w, int h, bit big);
        int     ci;
        int     cj;
        int     m;
        int     sel;
        longint dx;
        longint dz;
        longint off;
        longint qx;
        longint qz;
        m = $urandom_range(99);
        if (big) begin
            sel = $urandom_range(1);
            ci  = sel ? w - 2 : 0;
            cj  = sel ? h - 2 : 0;
        end else begin
            ci = $urandom_range(0, w - 2);
            cj = $urandom_range(0, h - 2);
        end
        qx = point_in(0, ci);
        qz = point_in(1, cj);
        if (m >= 60 && m < 75) begin
            dx  = ax[0][ci + 1] - ax[0][ci];
            dz  = ax[1][cj + 1] - ax[1][cj];
            off = (dx > 0 && dz > 0) ? longint'({$urandom, $urandom} % ((dx < dz ? dx : dz) + 1))
                                     : 0;
            qx  = ax[0][ci] + off;
            qz  = ax[1][cj] + off;
        end else if (m >= 75 && (m < 90 || big)) begin
            if ($urandom_range(1)) qx = $urandom_range(1) ? ax[0][0] - 1 : ax[0][w - 1] + 1;
            else qz = $urandom_range(1) ? ax[1][0] - 1 : ax[1][h - 1] + 1;
        end else if (m >= 90) begin
            qx = $urandom;
            qz = $urandom;
        end
        query(qx[31:0], qz[31:0]);
    endtask

    task automatic random_item(int w, int h);
        int          r;
        int          i;
        logic [2:0]  op;
        logic [31:0] v;
        r = $urandom_range(99);
        if (r < 62) begin
            gen_query(w, h, 1'b0);
        end else if (r < 85) begin
            op = 3'($urandom_range(OP_X_COORD, OP_SOLID));
            case (op)
                OP_X_COORD, OP_Z_COORD: begin
                    i = (op == OP_X_COORD) ? $urandom_range(0, w - 1) : $urandom_range(0, h - 1);
                    ax[op - 1][i] = ax[op - 1][i] + $urandom_range(0, 64) - 32;
                    v = ax[op - 1][i][31:0];
                    load(op, 16'(i), v);
                end
                OP_SOLID: load(op, 16'($urandom_range(0, (w - 1) * (h - 1) - 1)), $urandom);
                default:  load(op, 16'($urandom_range(0, w * h - 1)), rand_height());
            endcase
        end else if (r < 93) begin
            load($urandom_range(1) ? OP_X_COORD : OP_Z_COORD, 16'($urandom_range(256, 65535)),
                 $urandom);
        end else begin
            load(3'($urandom_range(6, 7)), 16'($urandom), $urandom);
        end
    endtask

    task automatic big_phase();
        int i;
        int c;
        configure(511, 256, 1);
        fill_axis(0, 256, 0);
        fill_axis(1, 256, 0);
        for (c = 0; c < 2; c++) begin
            i = c ? 254 * 256 + 254 : 0;
            load(OP_TOP, 16'(i), rand_height());
            load(OP_TOP, 16'(i + 1), rand_height());
            load(OP_TOP, 16'(i + 256), rand_height());
            load(OP_TOP, 16'(i + 257), rand_height());
            load(OP_BOTTOM, 16'(i), rand_height());
            load(OP_BOTTOM, 16'(i + 1), rand_height());
            load(OP_BOTTOM, 16'(i + 256), rand_height());
            load(OP_BOTTOM, 16'(i + 257), rand_height());
            load(OP_SOLID, c ? 16'(254 * 255 + 254) : 16'd0,
                 c ? 32'h0000_0001 : 32'hffff_ffff);
        end
        for (i = 0; i < 30; i++) gen_query(256, 256, 1'b1);
    endtask

    initial begin
        int phase;
        int w;
        int h;
        int d;
        int k;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= OP_QUERY;
        s_entry_index <= '0;
        s_entry_value <= '0;
        s_query_x     <= '0;
        s_query_z     <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        pready        <= 1'b1;
        requests      = 0;
        cfg_writes    = 0;
        send_idle     = 22;
        recv_idle     = 78;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        query(32'h8000_0000, 32'h7fff_ffff);
        query(32'h0, 32'h0);
        configure(2, 2, 0);
        build_lattice(2, 2, 1, 100);
        query(32'h8000_0000, 32'h8000_0000);
        query(32'h7fff_ffff, 32'h7fff_ffff);
        query(32'h7fff_ffff, 32'h8000_0000);
        query(32'h0000_1000, 32'h0000_1000);
        query(32'h1234_5678, 32'hedcb_a987);
        load(3'd6, 16'hffff, 32'hffff_ffff);
        load(3'd7, 16'h0000, 32'h0);
        load(OP_X_COORD, 16'd300, 32'h7fff_ffff);
        configure(2, 2, 1);
        query(32'h8000_0000, 32'h7fff_ffff);
        query(32'h4000_0000, 32'hc000_0000);

        phase = 0;
        while (requests < ITEM_TARGET) begin
            if (phase == 0) begin
                big_phase();
            end else if (phase % 5 == 4) begin
                if ($urandom_range(1)) configure($urandom_range(0, 1), $urandom_range(0, 511), 1);
                else configure($urandom_range(2, 511), $urandom_range(0, 1), 0);
                for (k = 0; k < 6; k++) query($urandom, $urandom);
            end else begin
                w = ($urandom_range(9) == 0) ? 8 : $urandom_range(2, 5);
                h = ($urandom_range(9) == 0) ? 8 : $urandom_range(2, 5);
                d = $urandom_range(1);
                configure(w, h, d);
                build_lattice(w, h, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0, 75);
                for (k = 0; k < 30; k++) begin
                    if (k == 15 && phase == 2) drain();
                    random_item(w, h);
                end
                configure(w, h, 1 - d);
                for (k = 0; k < 15; k++) random_item(w, h);
            end
            phase++;
        end

        drain();
        $display("covered %0d requests over %0d lattice phases and %0d register writes",
                 requests, phase, cfg_writes);
        $display("results: %0d out, %0d void, %0d solid", outs_seen, voids_seen, solids_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
